// ===== sv/tbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared types and constants of the text blank-line and trailing-space strip.
// ----------------------------------------------------------------------------
package tbs_pkg;

    localparam int HOLD_DEPTH = 32;
    localparam int ADDR_W     = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_COMMENTS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMENT_CHAR  = 1'b1;

    localparam logic [7:0] COMMENT_CHAR_RESET = 8'd35;

    localparam logic [7:0] LF_BYTE    = 8'h0A;
    localparam logic [7:0] CR_BYTE    = 8'h0D;
    localparam logic [7:0] TAB_BYTE   = 8'h09;
    localparam logic [7:0] SPACE_BYTE = 8'h20;

    // One command per input item that sends anything: an optional paragraph
    // LF, the held whitespace, the item's own byte and an optional closing LF.
    typedef struct packed {
        logic             pre_lf;
        logic [CNT_W-1:0] hcount;
        logic             has_byte;
        logic [7:0]       data;
        logic             post_lf;
        logic             ovf;
    } cmd_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_PRE,
        B_RD,
        B_HELD,
        B_BYTE,
        B_POST
    } back_state_t;

    function automatic logic is_ws(input logic [7:0] b);
        is_ws = (b == SPACE_BYTE) || (b == TAB_BYTE) || (b == LF_BYTE) || (b == CR_BYTE);
    endfunction

endpackage

// ===== sv/tbs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/tbs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_front
// Input side: tracks line and paragraph state, holds whitespace in the RAM
// and turns every input beat that sends anything into one output-side command.
// ----------------------------------------------------------------------------
module tbs_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tbs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     in_byte,
    input  logic                           in_last,
    output logic                           push,
    output tbs_pkg::cmd_t                  push_cmd,
    input  logic                           q_full,
    output logic                           ram_we,
    output logic [tbs_pkg::ADDR_W-1:0]     ram_waddr,
    output logic [7:0]                     ram_wdata,
    input  logic                           store_release
);

    logic                      skip_reg, skip_next;
    logic [7:0]                cchar_reg, cchar_next;
    logic [tbs_pkg::CNT_W-1:0] held_reg, held_next;
    logic                      at_ls_reg, at_ls_next;
    logic                      cl_reg, cl_next;
    logic                      lht_reg, lht_next;
    logic                      blank_reg, blank_next;
    logic                      any_reg, any_next;
    logic                      ovf_reg, ovf_next;
    logic                      busy_reg, busy_next;

    logic          accept;
    logic          cl_now;
    tbs_pkg::cmd_t cmd;

    // Hold input while the RAM is being drained or the queue has no room.
    assign in_stall = busy_reg || q_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        skip_next  = skip_reg;
        cchar_next = cchar_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                tbs_pkg::CFG_SKIP_COMMENTS: skip_next  = cfg_data[0];
                tbs_pkg::CFG_COMMENT_CHAR:  cchar_next = cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        held_next  = held_reg;
        at_ls_next = at_ls_reg;
        cl_next    = cl_reg;
        lht_next   = lht_reg;
        blank_next = blank_reg;
        any_next   = any_reg;
        ovf_next   = ovf_reg;
        ram_we     = 1'b0;
        ram_waddr  = held_reg[tbs_pkg::ADDR_W-1:0];
        ram_wdata  = in_byte;
        cmd        = '0;
        cl_now     = cl_reg || (at_ls_reg && skip_reg && (in_byte == cchar_reg));

        if (accept)
        begin
            at_ls_next = 1'b0;
            if (cl_now)
            begin
                cl_next = 1'b1;
                if (in_byte == tbs_pkg::LF_BYTE)
                begin
                    cl_next    = 1'b0;
                    at_ls_next = 1'b1;
                end
            end
            else if (in_byte == tbs_pkg::LF_BYTE)
            begin
                if (lht_reg)
                begin
                    cmd.has_byte = 1'b1;
                    cmd.data     = tbs_pkg::LF_BYTE;
                end
                else
                begin
                    blank_next = 1'b1;
                end
                held_next  = '0;
                lht_next   = 1'b0;
                at_ls_next = 1'b1;
            end
            else if (tbs_pkg::is_ws(in_byte))
            begin
                if (held_reg < tbs_pkg::CNT_W'(tbs_pkg::HOLD_DEPTH))
                begin
                    ram_we    = 1'b1;
                    held_next = held_reg + tbs_pkg::CNT_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            else
            begin
                if (!lht_reg)
                begin
                    cmd.pre_lf = blank_reg && any_reg;
                    blank_next = 1'b0;
                    lht_next   = 1'b1;
                end
                cmd.hcount   = held_reg;
                cmd.has_byte = 1'b1;
                cmd.data     = in_byte;
                held_next    = '0;
                any_next     = 1'b1;
            end

            if (in_last)
            begin
                cmd.post_lf = !at_ls_next && !cl_next && lht_next;
                held_next   = '0;
                at_ls_next  = 1'b1;
                cl_next     = 1'b0;
                lht_next    = 1'b0;
                blank_next  = 1'b0;
                any_next    = 1'b0;
            end
        end
        cmd.ovf = ovf_next;
    end

    // The paragraph LF and held bytes only come with a byte, so this covers all.
    assign push     = accept && (cmd.has_byte || cmd.post_lf);
    assign push_cmd = cmd;

    always_comb
    begin
        busy_next = busy_reg;
        if (store_release)
        begin
            busy_next = 1'b0;
        end
        if (push && (cmd.hcount != '0))
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg  <= 1'b0;
            cchar_reg <= tbs_pkg::COMMENT_CHAR_RESET;
            held_reg  <= '0;
            at_ls_reg <= 1'b1;
            cl_reg    <= 1'b0;
            lht_reg   <= 1'b0;
            blank_reg <= 1'b0;
            any_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            skip_reg  <= skip_next;
            cchar_reg <= cchar_next;
            held_reg  <= held_next;
            at_ls_reg <= at_ls_next;
            cl_reg    <= cl_next;
            lht_reg   <= lht_next;
            blank_reg <= blank_next;
            any_reg   <= any_next;
            ovf_reg   <= ovf_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

// ===== sv/tbs_cmd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_cmd_queue
// Short FIFO of commands between the input side and the output side.
// ----------------------------------------------------------------------------
module tbs_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tbs_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output tbs_pkg::cmd_t head,
    output logic          empty
);

    tbs_pkg::cmd_t              slot_reg [tbs_pkg::QUEUE_DEPTH];
    logic [tbs_pkg::QPTR_W-1:0] wptr_reg, wptr_next;
    logic [tbs_pkg::QPTR_W-1:0] rptr_reg, rptr_next;
    logic [tbs_pkg::QCNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == tbs_pkg::QCNT_W'(tbs_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == tbs_pkg::QPTR_W'(tbs_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : wptr_reg + tbs_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == tbs_pkg::QPTR_W'(tbs_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : rptr_reg + tbs_pkg::QPTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + tbs_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - tbs_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== sv/tbs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_back
// Output side: walks one command at a time, reads held whitespace from the
// RAM and sends the bytes through a registered output stage.
// ----------------------------------------------------------------------------
module tbs_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  tbs_pkg::cmd_t              q_head,
    output logic                       pop,
    output logic                       ram_re,
    output logic [tbs_pkg::ADDR_W-1:0] ram_raddr,
    input  logic [7:0]                 ram_rdata,
    output logic                       store_release,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [7:0]                 out_byte,
    output logic                       out_last,
    output logic                       ws_overflow
);

    tbs_pkg::back_state_t      state_reg, state_next;
    tbs_pkg::cmd_t             cmd_reg, cmd_next;
    logic [tbs_pkg::CNT_W-1:0] idx_reg, idx_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       ovf_reg;

    logic       slot_free;
    logic       load;
    logic [7:0] ld_byte;
    logic       ld_last;
    logic       held_done;

    assign slot_free = !out_valid_reg || !out_stall;
    assign held_done = (idx_reg == cmd_reg.hcount - tbs_pkg::CNT_W'(1));
    assign ram_raddr = idx_reg[tbs_pkg::ADDR_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tbs_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = tbs_pkg::B_PRE;
                end
            end
            tbs_pkg::B_PRE:
            begin
                if (!cmd_reg.pre_lf || slot_free)
                begin
                    state_next = (cmd_reg.hcount != '0) ? tbs_pkg::B_RD : tbs_pkg::B_BYTE;
                end
            end
            tbs_pkg::B_RD:
            begin
                state_next = tbs_pkg::B_HELD;
            end
            tbs_pkg::B_HELD:
            begin
                if (slot_free)
                begin
                    state_next = held_done ? tbs_pkg::B_BYTE : tbs_pkg::B_RD;
                end
            end
            tbs_pkg::B_BYTE:
            begin
                if (!cmd_reg.has_byte || slot_free)
                begin
                    state_next = tbs_pkg::B_POST;
                end
            end
            tbs_pkg::B_POST:
            begin
                if (!cmd_reg.post_lf || slot_free)
                begin
                    state_next = tbs_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = tbs_pkg::B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop           = 1'b0;
        ram_re        = 1'b0;
        load          = 1'b0;
        ld_byte       = tbs_pkg::LF_BYTE;
        ld_last       = 1'b0;
        store_release = 1'b0;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        case (state_reg)
            tbs_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    cmd_next = q_head;
                    idx_next = '0;
                end
            end
            tbs_pkg::B_PRE:
            begin
                load = cmd_reg.pre_lf && slot_free;
            end
            tbs_pkg::B_RD:
            begin
                ram_re = 1'b1;
            end
            tbs_pkg::B_HELD:
            begin
                if (slot_free)
                begin
                    load    = 1'b1;
                    ld_byte = ram_rdata;
                    if (held_done)
                    begin
                        // last read done: the input side may refill the RAM
                        store_release = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + tbs_pkg::CNT_W'(1);
                    end
                end
            end
            tbs_pkg::B_BYTE:
            begin
                load    = cmd_reg.has_byte && slot_free;
                ld_byte = cmd_reg.data;
                ld_last = !cmd_reg.post_lf;
            end
            tbs_pkg::B_POST:
            begin
                load    = cmd_reg.post_lf && slot_free;
                ld_last = 1'b1;
            end
            default: ;
        endcase
    end

    assign out_valid_next = slot_free ? load : out_valid_reg;

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        if (load)
        begin
            out_byte_reg <= ld_byte;
            out_last_reg <= ld_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tbs_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                ovf_reg <= cmd_reg.ovf;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign out_last    = out_last_reg;
    assign ws_overflow = ovf_reg;

endmodule

// ===== sv/text_blank_line_and_trailing_space_strip.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_blank_line_and_trailing_space_strip
// Strips trailing whitespace, collapses blank lines and, when enabled, drops
// comment lines of a byte stream.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | sink      | in_valid / in_stall  | in_byte, in_last
//  out     | source    | out_valid / out_stall| out_byte, out_last, ws_overflow
//  cfg     | sink      | cfg_we               | cfg_index, cfg_data
//
//  An input beat is taken whenever the command queue has room.
//  The output side walks each command: paragraph LF, each held whitespace
//  byte (RAM read, then output load), text byte, closing LF; it sets the rate.
//  Input stalls while held whitespace is being read out of the RAM.
//  Reset is asynchronous and needs no clearing pass; out_stall only holds
//  the output register and backs up the queue.
// ----------------------------------------------------------------------------
module text_blank_line_and_trailing_space_strip (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tbs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     in_byte,
    input  logic                           in_last,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     out_byte,
    output logic                           out_last,
    output logic                           ws_overflow
);

    logic                       push;
    tbs_pkg::cmd_t              push_cmd;
    logic                       q_full;
    logic                       pop;
    tbs_pkg::cmd_t              q_head;
    logic                       q_empty;
    logic                       ram_we;
    logic [tbs_pkg::ADDR_W-1:0] ram_waddr;
    logic [7:0]                 ram_wdata;
    logic                       ram_re;
    logic [tbs_pkg::ADDR_W-1:0] ram_raddr;
    logic [7:0]                 ram_rdata;
    logic                       store_release;

    tbs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .in_last       (in_last),
        .push          (push),
        .push_cmd      (push_cmd),
        .q_full        (q_full),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .store_release (store_release)
    );

    tbs_ram #(
        .WIDTH (8),
        .DEPTH (tbs_pkg::HOLD_DEPTH)
    ) u_held_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tbs_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    tbs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .pop           (pop),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .store_release (store_release),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .out_last      (out_last),
        .ws_overflow   (ws_overflow)
    );

endmodule

// ===== sv/tbs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_checker
// Port-level checks of the strip block, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tbs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       out_last,
    input logic       ws_overflow
);

    // A stalled output beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output beat changed while stalled");

    // Overflow is sticky once shown.
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ws_overflow |=> ws_overflow)
    else $error("ws_overflow dropped");

    // Held whitespace is always followed by its text byte, so it never ends a beat group.
    a_ws_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((out_byte == 8'h20) || (out_byte == 8'h09) || (out_byte == 8'h0D))
        |-> !out_last)
    else $error("whitespace byte marked last");

endmodule

bind text_blank_line_and_trailing_space_strip tbs_checker u_tbs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_last    (out_last),
    .ws_overflow (ws_overflow)
);
